@@ rtl/core/utf8_stream_decoder_macros.svh @@
// Assertion helpers for the UTF-8 decoder core.
// All checks sample on clk and are off while rst_n is low.
`ifndef UTF8_STREAM_DECODER_MACROS_SVH
`define UTF8_STREAM_DECODER_MACROS_SVH

// Check a property every cycle outside reset.
`define U8D_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define U8D_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

@@ rtl/core/u8d_pkg.sv @@
package u8d_pkg;

  localparam int CP_W   = 31;
  localparam int PEND_W = 3;

  typedef enum logic [1:0] {
    SKIP_NONE,
    SKIP_CONT,
    SKIP_ILLEGAL
  } skip_mode_t;

  typedef enum logic [1:0] {
    ERR_NONE,
    ERR_STRAY_CONT,
    ERR_ILLEGAL
  } err_kind_t;

  typedef struct packed {
    logic [PEND_W-1:0] pending;
    logic [CP_W-1:0]   acc;
    skip_mode_t        skip;
  } dec_state_t;

  typedef struct packed {
    logic            emit;
    logic [CP_W-1:0] code;
    err_kind_t       err;
  } dec_result_t;

endpackage

@@ rtl/core/utf8_stream_decoder.sv @@
// A result appears on out_* in the cycle after the byte that completes it is taken.
// Throughput: one byte per cycle; the decode step sits between the input port and the
// result register, and a new byte is taken whenever the result register is empty or drained.
// Reset (rst_n low, synchronous): pending count, accumulator and run state clear,
// and the result register empties.
`include "utf8_stream_decoder_macros.svh"

module utf8_stream_decoder (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [7:0]               in_byte_in,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [u8d_pkg::CP_W-1:0] out_code_point,
  output logic [1:0]               out_error_kind
);
  import u8d_pkg::*;

  dec_state_t      state_r;
  dec_state_t      state_nxt;
  dec_result_t     step_res;
  logic            in_xfer;
  logic            out_valid_r;
  logic [CP_W-1:0] code_r;
  err_kind_t       err_r;

  u8d_step u_step (
    .byte_i    (in_byte_in),
    .state_i   (state_r),
    .state_nxt (state_nxt),
    .result    (step_res)
  );

  assign in_ready = !out_valid_r || out_ready;
  assign in_xfer  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.pending <= '0;
      state_r.acc     <= '0;
      state_r.skip    <= SKIP_NONE;
      out_valid_r     <= 1'b0;
    end else begin
      if (in_xfer) begin
        state_r     <= state_nxt;
        out_valid_r <= step_res.emit;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Load the result register only on a byte that produces a result.
  always_ff @(posedge clk) begin
    if (in_xfer && step_res.emit) begin
      code_r <= step_res.code;
      err_r  <= step_res.err;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_code_point = code_r;
  assign out_error_kind = 2'(err_r);

  `U8D_NEVER(a_pend_no_skip, (state_r.pending != '0) && (state_r.skip != SKIP_NONE), "run state set while a sequence is open")
  `U8D_ASSERT(a_err_zero_code, (out_valid_r && (err_r != ERR_NONE)) |-> (code_r == '0), "error result with nonzero code point")
  `U8D_ASSERT(a_ascii_pass, (in_xfer && (state_r.pending == '0) && !in_byte_in[7]) |=> (out_valid_r && (code_r == {{(CP_W-8){1'b0}}, $past(in_byte_in)}) && (err_r == ERR_NONE)), "ASCII byte not passed through")
  `U8D_ASSERT(a_mid_seq_quiet, (in_xfer && (state_r.pending > PEND_W'(1))) |=> !out_valid_r, "result emitted before sequence end")

endmodule

@@ rtl/core/u8d_step.sv @@
module u8d_step (
  input  logic [7:0]           byte_i,
  input  u8d_pkg::dec_state_t  state_i,
  output u8d_pkg::dec_state_t  state_nxt,
  output u8d_pkg::dec_result_t result
);
  import u8d_pkg::*;

  logic run_hold;

  // Continuation bytes inside a stray run, or 0xFE/0xFF inside an illegal run, are dropped.
  assign run_hold = ((state_i.skip == SKIP_CONT) && (byte_i[7:6] == 2'b10)) ||
                    ((state_i.skip == SKIP_ILLEGAL) && (byte_i[7:1] == 7'h7F));

  always_comb begin
    state_nxt   = state_i;
    result.emit = 1'b0;
    result.code = '0;
    result.err  = ERR_NONE;
    if (state_i.pending != '0) begin
      // Trailing byte: shift in low six bits, top bits unchecked.
      state_nxt.acc     = {state_i.acc[CP_W-7:0], byte_i[5:0]};
      state_nxt.pending = state_i.pending - PEND_W'(1);
      if (state_i.pending == PEND_W'(1)) begin
        result.emit = 1'b1;
        result.code = {state_i.acc[CP_W-7:0], byte_i[5:0]};
      end
    end else if (!run_hold) begin
      state_nxt.skip = SKIP_NONE;
      unique casez (byte_i)
        8'b0???????: begin
          result.emit = 1'b1;
          result.code = {{(CP_W-8){1'b0}}, byte_i};
        end
        8'b10??????: begin
          state_nxt.skip = SKIP_CONT;
          result.emit    = 1'b1;
          result.err     = ERR_STRAY_CONT;
        end
        8'b110?????: begin
          state_nxt.acc     = {{(CP_W-5){1'b0}}, byte_i[4:0]};
          state_nxt.pending = PEND_W'(1);
        end
        8'b1110????: begin
          state_nxt.acc     = {{(CP_W-4){1'b0}}, byte_i[3:0]};
          state_nxt.pending = PEND_W'(2);
        end
        8'b11110???: begin
          state_nxt.acc     = {{(CP_W-3){1'b0}}, byte_i[2:0]};
          state_nxt.pending = PEND_W'(3);
        end
        8'b111110??: begin
          state_nxt.acc     = {{(CP_W-2){1'b0}}, byte_i[1:0]};
          state_nxt.pending = PEND_W'(4);
        end
        8'b1111110?: begin
          state_nxt.acc     = {{(CP_W-1){1'b0}}, byte_i[0]};
          state_nxt.pending = PEND_W'(5);
        end
        default: begin
          state_nxt.skip = SKIP_ILLEGAL;
          result.emit    = 1'b1;
          result.err     = ERR_ILLEGAL;
        end
      endcase
    end
  end

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps

module tb;
  import u8d_pkg::*;

  localparam int NUM_BYTES   = 1600;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic [CP_W-1:0] code;
    err_kind_t       err;
  } decoded_char_t;

  typedef enum {
    GEN_CHAR,
    GEN_STRAY,
    GEN_ILLEGAL,
    GEN_NOISE
  } gen_kind_t;

  // Tracks the decoder state and the characters still owed by the block.
  class utf8_char_tracker;
    logic [PEND_W-1:0] pend;
    logic [CP_W-1:0]   acc;
    skip_mode_t        skip;
    decoded_char_t     pending_chars[$];
    int                bad_count;
    int                chars_seen;
    int                err_seen[3];

    function new();
      pend = '0;
      acc  = '0;
      skip = SKIP_NONE;
      bad_count  = 0;
      chars_seen = 0;
      err_seen   = '{0, 0, 0};
    endfunction

    task report_bad(string what);
      bad_count++;
      $display("[%0t] ERROR: %s", $realtime, what);
    endtask

    function void take_byte(logic [7:0] b);
      decoded_char_t c;
      logic          emit;
      emit = 1'b0;
      c.code = '0;
      c.err  = ERR_NONE;
      if (pend != 0) begin
        // any byte counts as a trailing byte here
        acc  = {acc[CP_W-7:0], b[5:0]};
        pend = pend - 3'd1;
        if (pend == 0) begin
          emit   = 1'b1;
          c.code = acc;
        end
      end else if (skip == SKIP_CONT && b[7:6] == 2'b10) begin
        // drop: still inside a stray continuation run
      end else if (skip == SKIP_ILLEGAL && b[7:1] == 7'h7F) begin
        // drop: still inside a 0xFE/0xFF run
      end else begin
        skip = SKIP_NONE;
        casez (b)
          8'b0???????: begin
            emit   = 1'b1;
            c.code = {{(CP_W-8){1'b0}}, b};
          end
          8'b10??????: begin
            skip  = SKIP_CONT;
            emit  = 1'b1;
            c.err = ERR_STRAY_CONT;
          end
          8'b110?????: begin acc = {{(CP_W-5){1'b0}}, b[4:0]}; pend = 3'd1; end
          8'b1110????: begin acc = {{(CP_W-4){1'b0}}, b[3:0]}; pend = 3'd2; end
          8'b11110???: begin acc = {{(CP_W-3){1'b0}}, b[2:0]}; pend = 3'd3; end
          8'b111110??: begin acc = {{(CP_W-2){1'b0}}, b[1:0]}; pend = 3'd4; end
          8'b1111110?: begin acc = {{(CP_W-1){1'b0}}, b[0]};   pend = 3'd5; end
          default: begin
            skip  = SKIP_ILLEGAL;
            emit  = 1'b1;
            c.err = ERR_ILLEGAL;
          end
        endcase
      end
      if (emit) pending_chars.push_back(c);
    endfunction

    task match_char(logic [CP_W-1:0] code, logic [1:0] err);
      decoded_char_t c;
      if (pending_chars.size() == 0) begin
        report_bad($sformatf("unexpected result code_point=%0h error_kind=%0d", code, err));
        return;
      end
      c = pending_chars.pop_front();
      chars_seen++;
      if (err <= 2) err_seen[err]++;
      if (code !== c.code)
        report_bad($sformatf("wrong code_point: got %0h, want %0h", code, c.code));
      if (err !== c.err)
        report_bad($sformatf("wrong error_kind: got %0d, want %0d", err, c.err));
    endtask
  endclass

  logic            clk;
  logic            rst_n;
  logic            in_valid;
  logic            in_ready;
  logic [7:0]      in_byte_in;
  logic            out_valid;
  logic            out_ready;
  logic [CP_W-1:0] out_code_point;
  logic [1:0]      out_error_kind;

  utf8_char_tracker tracker;
  int               cycles;
  int               bytes_sent;
  int               burst_left;
  bit               hold_req;
  bit               hold_done;

  utf8_stream_decoder dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_byte_in     (in_byte_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_code_point (out_code_point),
    .out_error_kind (out_error_kind)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    tracker = new();
  end

  // Watch both channels at the rising edge.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n) begin
      if (in_valid && in_ready) tracker.take_byte(in_byte_in);
      if (out_valid && out_ready) tracker.match_char(out_code_point, out_error_kind);
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("utf8_stream_decoder: mismatch");
      $finish;
    end
  end

  // Receiver: stall patterns that change every so often, plus one long hold-off.
  initial begin
    int mode;
    int len;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      mode = $urandom_range(0, 2);
      len  = $urandom_range(20, 150);
      repeat (len) begin
        @(negedge clk);
        if (hold_req) begin
          out_ready <= 1'b0;
          repeat (HOLD_CYCLES) @(negedge clk);
          hold_req  = 1'b0;
          hold_done = 1'b1;
        end else begin
          case (mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= 1'($urandom_range(0, 1));
            default: out_ready <= ($urandom_range(0, 3) == 0);
          endcase
        end
      end
    end
  end

  // Drive one byte at the falling edge and hold it until the transfer.
  task automatic send_byte(logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 24);
    end
    in_valid   <= 1'b1;
    in_byte_in <= b;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    burst_left--;
    bytes_sent++;
  endtask

  task automatic send_char(int nbytes);
    logic [7:0] lead;
    logic [7:0] r;
    r = 8'($urandom_range(0, 255));
    case (nbytes)
      1:       lead = {1'b0, r[6:0]};
      2:       lead = {3'b110, r[4:0]};
      3:       lead = {4'b1110, r[3:0]};
      4:       lead = {5'b11110, r[2:0]};
      5:       lead = {6'b111110, r[1:0]};
      default: lead = {7'b1111110, r[0]};
    endcase
    send_byte(lead);
    repeat (nbytes - 1) begin
      r = 8'($urandom_range(0, 255));
      // mostly proper continuation bytes, now and then anything
      send_byte(($urandom_range(0, 7) == 0) ? r : {2'b10, r[5:0]});
    end
  endtask

  initial begin
    logic [7:0] directed[$];
    gen_kind_t  kind;
    int         pick;
    logic [7:0] r;

    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_byte_in = 8'h00;
    cycles     = 0;
    bytes_sent = 0;
    burst_left = 0;
    hold_req   = 1'b0;
    hold_done  = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // ASCII extremes, every lead length, non-continuation
    // bytes taken as trailing, then an illegal run flowing into a stray run.
    directed = '{8'h00, 8'h7F,
                 8'hC3, 8'h41,
                 8'hEF, 8'hFF, 8'hBF,
                 8'hF7, 8'hBF, 8'hBF, 8'hBF,
                 8'hF8, 8'h88, 8'h80, 8'h80, 8'h80,
                 8'hFD, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF,
                 8'hFE, 8'hFF, 8'h80, 8'hBF, 8'h41};
    foreach (directed[i]) send_byte(directed[i]);

    while (bytes_sent < NUM_BYTES) begin
      if (!hold_done && !hold_req && bytes_sent >= 500) hold_req = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 60)      kind = GEN_CHAR;
      else if (pick < 75) kind = GEN_STRAY;
      else if (pick < 85) kind = GEN_ILLEGAL;
      else                kind = GEN_NOISE;
      case (kind)
        GEN_CHAR: send_char($urandom_range(1, 6));
        GEN_STRAY: begin
          repeat ($urandom_range(1, 4)) begin
            r = 8'($urandom_range(0, 255));
            send_byte({2'b10, r[5:0]});
          end
        end
        GEN_ILLEGAL: begin
          repeat ($urandom_range(1, 3)) begin
            r = 8'($urandom_range(0, 255));
            send_byte({7'h7F, r[0]});
          end
        end
        default: send_byte(8'($urandom_range(0, 255)));
      endcase
    end
    in_valid <= 1'b0;

    while (tracker.pending_chars.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (tracker.pending_chars.size() != 0)
      tracker.report_bad($sformatf("%0d results never arrived", tracker.pending_chars.size()));

    $display("sent %0d bytes in %0d cycles, one long receiver hold-off: %0s",
             bytes_sent, cycles, hold_done ? "yes" : "no");
    $display("checked %0d results: %0d characters, %0d stray runs, %0d illegal runs",
             tracker.chars_seen, tracker.err_seen[ERR_NONE],
             tracker.err_seen[ERR_STRAY_CONT], tracker.err_seen[ERR_ILLEGAL]);
    if (tracker.bad_count == 0) begin
      $display("utf8_stream_decoder: match");
    end else begin
      $display("utf8_stream_decoder: mismatch");
    end
    $finish;
  end

endmodule
